// ===== rtl/selection_key_table_unit_defines.svh =====
// Assertion macros used by the selection key table top level.
`ifndef SELECTION_KEY_TABLE_UNIT_DEFINES_SVH
`define SELECTION_KEY_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SKT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SKT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SKT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define SKT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/skt_pkg.sv =====
// Types, operation codes and constants of the selection key table.
package skt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KIND_W       = 3;
	localparam int OBJ_W        = 12;
	localparam int PT_W         = 17;
	localparam int COUNT_W      = 7;
	localparam int COUNT_MAX    = 127;

	localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TOGGLE = 3'd4;

	localparam logic signed [PT_W-1:0] NOT_FOUND_PT = -17'sd2;

	typedef struct packed {
		logic signed [PT_W-1:0] pnt;
		logic signed [PT_W-1:0] con;
		logic [OBJ_W-1:0]       obj;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [OBJ_W-1:0]       object_id;
		logic signed [PT_W-1:0] contour_id;
		logic signed [PT_W-1:0] point_id;
	} req_t;

	typedef struct packed {
		logic                   found;
		logic signed [PT_W-1:0] point_out;
		logic [COUNT_W-1:0]     count_out;
		logic                   last_valid;
		logic [OBJ_W-1:0]       last_object;
		logic signed [PT_W-1:0] last_contour;
		logic signed [PT_W-1:0] last_point;
		logic                   full_error;
	} rsp_t;

endpackage

// ===== rtl/selection_key_table_unit.sv =====
// Top level of the selection key table: stream ports, result register, checks.
//
// Ordered table of (object, contour, point) entries keyed by object and contour.
// Slave channel s_*: one command item per transfer, kind in s_tuser
// (add, query, remove, clear, toggle), key and point in s_tdata.
// Master channel m_*: exactly one result item per command, in command order.
// Add, query, remove and toggle walk the stored entries through the table RAM,
// one read per cycle; matching, point update and removal compaction happen in
// that pass. Clear and unused kinds skip the walk. One command is in work at a
// time and the next one is taken in the cycle after the result moves to the output
// register.
// A finished result sits in the output register; a new command is accepted while
// it waits. If the receiver stalls with the register still full, the next result
// holds in the engine and s_tready stays low until the register frees.
// Reset empties the table (entry count to zero) with no clearing pass and drops
// any result not yet taken; table contents stay undefined until written.
`include "selection_key_table_unit_defines.svh"

module selection_key_table_unit import skt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // object_id[11:0], contour_id[28:12], point_id[45:29], zero pad
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0], point_out[17:1], count_out[24:18], last_valid[25], last_object[37:26],
	// last_contour[54:38], last_point[71:55], full_error[72], zero pad
	output logic [79:0] m_tdata
);

	req_t req;
	rsp_t rsp;
	logic rsp_valid;
	logic out_free;
	logic m_tvalid_q;
	logic [79:0] m_tdata_q;

	assign req.kind       = s_tuser;
	assign req.object_id  = s_tdata[11:0];
	assign req.contour_id = s_tdata[28:12];
	assign req.point_id   = s_tdata[45:29];

	assign out_free = !m_tvalid_q || m_tready;

	skt_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req       (req),
		.req_ready (s_tready),
		.out_free  (out_free),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rsp_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid) begin
			m_tdata_q <= {7'b0, rsp.full_error, rsp.last_point, rsp.last_contour,
				rsp.last_object, rsp.last_valid, rsp.count_out, rsp.point_out, rsp.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SKT_ASSERT_NXT(a_one_in_work, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"second command accepted while one is in work")
	`SKT_ASSERT_IMP(a_count_bound, clk, arst_n, m_tvalid, 32'(m_tdata[24:18]) <= CAPACITY,
		"reported count exceeds capacity")
	`SKT_ASSERT_IMP(a_full_absent, clk, arst_n, m_tvalid && m_tdata[72],
		!m_tdata[0] && !m_tdata[25], "full error on a key that was found")
	`SKT_ASSERT_IMP(a_last_found, clk, arst_n, m_tvalid && m_tdata[25], m_tdata[0],
		"last entry reported without a removed key")

endmodule

// ===== rtl/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/skt_engine.sv =====
// Table walker: for add, query, remove and toggle one pass reads every entry, matches, updates and compacts in place.
module skt_engine import skt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_ready,
	input  logic out_free,
	output logic rsp_valid,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_addr_q;
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic          found_q;
	logic          rm_q;
	logic signed [PT_W-1:0] pnt_q;
	entry_t        last_q;

	logic          issue;
	logic [ENTRY_W-1:0] rd_raw;
	entry_t        rd_entry;
	logic          obj_eq, con_eq, ex_hit, any_hit, hit;
	logic          use_any, removing, drop_now, needs_scan;
	logic          fin_go, is_append, room;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [CW-1:0] cnt_next;
	logic [CW-1:0] cnt_rep;
	logic [XW-1:0] cnt_ext;

	assign issue    = (state_q == ST_SCAN) && (rd_addr_q != count_q);
	assign rd_entry = entry_t'(rd_raw);

	assign obj_eq   = rd_entry.obj == req_q.object_id;
	assign con_eq   = rd_entry.con == req_q.contour_id;
	assign ex_hit   = obj_eq && con_eq;
	// negative contour matches any contour of the object
	assign any_hit  = obj_eq && (con_eq || req_q.contour_id[PT_W-1]);
	assign use_any  = (req_q.kind == KIND_QUERY) || (req_q.kind == KIND_TOGGLE);
	assign hit      = use_any ? any_hit : ex_hit;
	assign removing = (req_q.kind == KIND_REMOVE) || (req_q.kind == KIND_TOGGLE);
	assign drop_now = removing && ex_hit && !rm_q;

	assign needs_scan = (req.kind == KIND_ADD) || (req.kind == KIND_QUERY) ||
		(req.kind == KIND_REMOVE) || (req.kind == KIND_TOGGLE);

	assign fin_go    = (state_q == ST_FIN) && out_free;
	assign is_append = ((req_q.kind == KIND_ADD) || (req_q.kind == KIND_TOGGLE)) && !found_q;
	assign room      = count_q < CW'(CAPACITY);

	// Writes trail reads, so a write never lands on an entry still to be read.
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rd_entry;
		if (valid_s1 && removing && rm_q && !drop_now) begin
			we    = 1'b1;
			waddr = AW'(addr_s1 - 1'b1);
			wdata = rd_entry;
		end else if (valid_s1 && (req_q.kind == KIND_ADD) && ex_hit && !found_q) begin
			we        = 1'b1;
			waddr     = addr_s1;
			wdata.obj = req_q.object_id;
			wdata.con = req_q.contour_id;
			wdata.pnt = req_q.point_id;
		end else if (fin_go && is_append && room) begin
			we        = 1'b1;
			waddr     = count_q[AW-1:0];
			wdata.obj = req_q.object_id;
			wdata.con = req_q.contour_id;
			wdata.pnt = req_q.point_id;
		end
	end

	skt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (ENTRY_W'(wdata)),
		.re    (issue),
		.raddr (rd_addr_q[AW-1:0]),
		.rdata (rd_raw)
	);

	always_comb begin
		cnt_next = count_q;
		if (is_append && room) begin
			cnt_next = CW'(count_q + 1'b1);
		end else if (removing && rm_q) begin
			cnt_next = CW'(count_q - 1'b1);
		end else if (req_q.kind == KIND_CLEAR) begin
			cnt_next = '0;
		end
	end

	assign cnt_rep = (req_q.kind == KIND_CLEAR) ? count_q : cnt_next;
	assign cnt_ext = XW'(cnt_rep);

	always_comb begin
		rsp            = '0;
		rsp.found      = found_q;
		rsp.point_out  = found_q ? pnt_q : NOT_FOUND_PT;
		rsp.count_out  = (cnt_ext > XW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : cnt_ext[COUNT_W-1:0];
		rsp.last_valid = (req_q.kind == KIND_TOGGLE) && found_q && (cnt_next != '0);
		if (rsp.last_valid) begin
			rsp.last_object  = last_q.obj;
			rsp.last_contour = last_q.con;
			rsp.last_point   = last_q.pnt;
		end
		rsp.full_error = is_append && !room;
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = fin_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_addr_q <= '0;
			valid_s1  <= 1'b0;
			found_q   <= 1'b0;
			rm_q      <= 1'b0;
		end else begin
			valid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						found_q   <= 1'b0;
						rm_q      <= 1'b0;
						rd_addr_q <= '0;
						state_q   <= needs_scan ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_addr_q <= CW'(rd_addr_q + 1'b1);
					end else if (!valid_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						count_q <= cnt_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (valid_s1) begin
				if (hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (drop_now) begin
					rm_q <= 1'b1;
				end
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_q <= req;
		end
		if (issue) begin
			addr_s1 <= rd_addr_q[AW-1:0];
		end
		if (valid_s1) begin
			if (hit && !found_q) begin
				pnt_q <= rd_entry.pnt;
			end
			// track the last entry that survives compaction
			if (!drop_now) begin
				last_q <= rd_entry;
			end
		end
	end

endmodule
